// File: src/ftdt_pkg.sv
`default_nettype none

package ftdt_pkg;

  localparam logic [5:0] CH_MINUS = 6'd45;
  localparam logic [5:0] CH_POINT = 6'd46;
  localparam logic [5:0] CH_ZERO  = 6'd48;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_MINUS,
    S_INT,
    S_POINT,
    S_FRAC
  } state_e;

endpackage

`default_nettype wire

// File: src/fixed_to_decimal_text_top.sv
// channel  | ports                          | handshake
// ---------+--------------------------------+-----------------------------
// command  | value_i, frac_digits_i         | start_i high while busy_o low
// text     | char_code_o, last_o            | char_valid_o, one cycle each
//
// a number is accepted in idle; its 48 - FRAC_BITS integer bits go through shift-add-3
// binary to bcd, one bit a cycle; then come a minus sign if negative, one beat per bcd
// digit (leading zeros give no beat, the units digit always does), the point, and one
// beat per fractional digit, frac_digits_i clamped to MAX_FRAC_DIGITS
// busy_o stays high from the accepted command until the last beat is out
// reset clears the sequencer; the receiver cannot stall the text channel
`default_nettype none

module fixed_to_decimal_text_top
  import ftdt_pkg::*;
#(
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 9
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [47:0] value_i,
  input  wire logic        [3:0]  frac_digits_i,
  output logic                    char_valid_o,
  output logic             [5:0]  char_code_o,
  output logic                    last_o
);

  localparam int IW = 48 - FRAC_BITS;
  localparam int ND = (IW * 30103) / 100000 + 1;
  localparam int BW = ND * 4;
  localparam int CW = $clog2(IW + 1);
  localparam int DW = $clog2(MAX_FRAC_DIGITS + 1);

  state_e                 state_q, state_d;
  logic                   neg_q, neg_d;
  logic                   seen_q, seen_d;
  logic [IW-1:0]          ip_q, ip_d;
  logic [BW-1:0]          bcd_q, bcd_d;
  logic [FRAC_BITS-1:0]   frac_q, frac_d;
  logic [DW-1:0]          digs_q, digs_d;
  logic [CW-1:0]          cnt_q, cnt_d;

  logic [47:0]            mag;
  logic [DW-1:0]          digs_in;
  logic [BW-1:0]          adj;
  logic [3:0]             top_dig;
  logic [FRAC_BITS+3:0]   prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    seen_q <= seen_d;
    ip_q   <= ip_d;
    bcd_q  <= bcd_d;
    frac_q <= frac_d;
    digs_q <= digs_d;
    cnt_q  <= cnt_d;
  end

  always_comb begin
    mag = value_i[47] ? (~value_i + 48'd1) : value_i;
    if ({1'b0, frac_digits_i} > 5'(MAX_FRAC_DIGITS)) begin
      digs_in = DW'(MAX_FRAC_DIGITS);
    end else begin
      digs_in = DW'(frac_digits_i);
    end
    for (int j = 0; j < ND; j++) begin
      if (bcd_q[j*4 +: 4] >= 4'd5) begin
        adj[j*4 +: 4] = bcd_q[j*4 +: 4] + 4'd3;
      end else begin
        adj[j*4 +: 4] = bcd_q[j*4 +: 4];
      end
    end
    top_dig = bcd_q[BW-1 -: 4];
    prod = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1);
  end

  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    seen_d       = seen_q;
    ip_d         = ip_q;
    bcd_d        = bcd_q;
    frac_d       = frac_q;
    digs_d       = digs_q;
    cnt_d        = cnt_q;
    busy_o       = (state_q != S_IDLE);
    char_valid_o = 1'b0;
    char_code_o  = CH_ZERO;
    last_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          neg_d   = value_i[47];
          ip_d    = mag[47:FRAC_BITS];
          frac_d  = mag[FRAC_BITS-1:0];
          digs_d  = digs_in;
          bcd_d   = '0;
          cnt_d   = CW'(IW);
          state_d = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d = {adj[BW-2:0], ip_q[IW-1]};
        ip_d  = ip_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          cnt_d   = CW'(ND);
          seen_d  = 1'b0;
          state_d = neg_q ? S_MINUS : S_INT;
        end
      end
      S_MINUS: begin
        char_valid_o = 1'b1;
        char_code_o  = CH_MINUS;
        state_d      = S_INT;
      end
      S_INT: begin
        if (seen_q || (top_dig != 4'd0) || (cnt_q == CW'(1))) begin
          char_valid_o = 1'b1;
          char_code_o  = CH_ZERO + {2'b00, top_dig};
          seen_d       = 1'b1;
        end
        bcd_d = bcd_q << 4;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = S_POINT;
        end
      end
      S_POINT: begin
        char_valid_o = 1'b1;
        char_code_o  = CH_POINT;
        last_o       = (digs_q == '0);
        cnt_d        = CW'(digs_q);
        state_d      = (digs_q == '0) ? S_IDLE : S_FRAC;
      end
      S_FRAC: begin
        char_valid_o = 1'b1;
        char_code_o  = CH_ZERO + {2'b00, prod[FRAC_BITS+3:FRAC_BITS]};
        last_o       = (cnt_q == CW'(1));
        frac_d       = prod[FRAC_BITS-1:0];
        cnt_d        = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
